### src/ipnat_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and one's-complement helpers for the IPv4 port NAT rewriter.
// No dependencies.
package ipnat_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_PROXY_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_TCP_PROXY_PORT = 2'd1;
   localparam logic [1:0] CSR_UDP_PROXY_PORT = 2'd2;

   localparam logic [31:0] PROXY_ADDRESS_RESET  = 32'h0A00_0001;
   localparam logic [15:0] TCP_PROXY_PORT_RESET = 16'd10080;
   localparam logic [15:0] UDP_PROXY_PORT_RESET = 16'd10053;

   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [15:0] MIN_PACKET    = 16'd20;
   localparam logic [5:0]  MIN_HEADER    = 6'd20;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic        rewritten;
      logic [31:0] new_address;
      logic [15:0] new_port;
      logic [15:0] ip_header_checksum;
      logic [15:0] transport_checksum;
      logic [5:0]  header_length;
      logic [7:0]  protocol_number;
      logic [15:0] client_port;
      logic [31:0] remote_address;
      logic [15:0] server_port;
      logic [15:0] packet_length;
      logic        telemetry_valid;
   } rsp_word_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic [15:0] port;
   } nat_entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } tbl_req_type;

   // Finished packet summary, taken at the last byte
   typedef struct packed {
      logic [15:0] n;
      logic [5:0]  ihl;
      logic [7:0]  proto;
      logic        dir;
      logic [31:0] src_a;
      logic [31:0] dst_a;
      logic [15:0] src_p;
      logic [15:0] dst_p;
      logic [15:0] hsum;
      logic [15:0] tsum;
   } sum_stage_type;

   // Decisions and partial sums, waiting for the table read
   typedef struct packed {
      logic [15:0] n;
      logic [5:0]  ihl;
      logic [7:0]  proto;
      logic        is_tcp;
      logic        is_udp;
      logic        dir;
      logic        out_rw;
      logic        other_tel;
      logic        in_cand;
      logic [31:0] src_a;
      logic [31:0] dst_a;
      logic [15:0] src_p;
      logic [15:0] dst_p;
      logic [31:0] proxy_a;
      logic [15:0] proxy_p;
      logic [15:0] ip_part;
      logic [15:0] t_part;
   } look_stage_type;

   // One end-around fold of a 17-bit sum
   function automatic logic [15:0] oc_fold17(input logic [16:0] s);
      logic [16:0] r;
      r = {1'b0, s[15:0]} + {16'b0, s[16]};
      return r[15:0];
   endfunction

   // Two end-around folds of a sum of up to sixteen words
   function automatic logic [15:0] oc_fold20(input logic [19:0] s);
      logic [16:0] r1;
      logic [16:0] r2;
      r1 = {1'b0, s[15:0]} + {13'b0, s[19:16]};
      r2 = {1'b0, r1[15:0]} + {16'b0, r1[16]};
      return r2[15:0];
   endfunction

endpackage

### src/ipnat_table.sv
`timescale 1ns / 1ps
// NAT table: one-port memory of entries indexed by port, with a clearing pass after reset.
// Depends on ipnat_pkg.
module ipnat_table #(
   parameter int PORT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ipnat_pkg::tbl_req_type req,
   input  logic [PORT_BITS-1:0]   index,
   input  ipnat_pkg::nat_entry_type wr_entry,
   output ipnat_pkg::nat_entry_type rd_entry,
   output logic                   busy
);
   import ipnat_pkg::*;

   localparam int DEPTH = 1 << PORT_BITS;

   nat_entry_type        mem [DEPTH];
   nat_entry_type        rd_ff;
   logic [PORT_BITS-1:0] clr_idx_ff;
   logic [PORT_BITS-1:0] clr_idx_in;
   logic                 clearing_ff;
   logic                 clearing_in;

   // Advance the clearing sweep, one entry a cycle
   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + PORT_BITS'(1);
         if (clr_idx_ff == {PORT_BITS{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clearing_ff <= clearing_in;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (req.wr_en) begin
         mem[index] <= wr_entry;
      end
      if (req.rd_en) begin
         rd_ff <= mem[index];
      end
   end

   assign rd_entry = rd_ff;
   assign busy     = clearing_ff;

endmodule

### src/ipv4_port_nat_rewriter.sv
`timescale 1ns / 1ps
// Top level of the IPv4 port NAT rewriter: byte absorber, decision stage, table lookup, result.
// Depends on ipnat_pkg and ipnat_table.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_word_type, one packet byte
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_word_type, one per packet
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One byte is taken every cycle while req_stall is low. The result of a packet passes the
// summary register, the table read register and the result register after its last byte.
// After reset both tables are swept clear, one entry a cycle, while req_stall stays high;
// configuration writes are taken throughout.
// A stalled result holds its register; bytes keep flowing until the summary, lookup and
// result registers are all full with the result stalled.
module ipv4_port_nat_rewriter #(
   parameter int PORT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ipnat_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ipnat_pkg::rsp_word_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_data
);
   import ipnat_pkg::*;

   // Configuration registers
   logic [31:0] proxy_a_ff;
   logic [15:0] tcp_port_ff;
   logic [15:0] udp_port_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         proxy_a_ff  <= PROXY_ADDRESS_RESET;
         tcp_port_ff <= TCP_PROXY_PORT_RESET;
         udp_port_ff <= UDP_PROXY_PORT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PROXY_ADDRESS) begin
            proxy_a_ff <= csr_data;
         end
         if (csr_index == CSR_TCP_PROXY_PORT) begin
            tcp_port_ff <= csr_data[15:0];
         end
         if (csr_index == CSR_UDP_PROXY_PORT) begin
            udp_port_ff <= csr_data[15:0];
         end
      end
   end

   // Pipeline flow control
   logic           s1_valid_ff, s1_valid_in;
   logic           s2_valid_ff, s2_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sum_stage_type  s1_ff;
   look_stage_type s2_ff, s2_in;
   rsp_word_type   rsp_ff, rsp_in;
   logic           out_free, s2_move, s2_free, s1_move, s1_free;
   logic           busy, tcp_busy, udp_busy, accept, last_acc;

   assign busy      = tcp_busy || udp_busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = busy || !s1_free;
   assign accept    = req_valid && !req_stall;
   assign last_acc  = accept && req_data.last;

   // Byte absorber state
   logic [15:0] cnt_ff, cnt_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [7:0]  proto_ff, proto_in;
   logic        dir_ff, dir_in;
   logic [63:0] addrs_ff, addrs_in;
   logic [31:0] ports_ff, ports_in;
   logic [15:0] hsum_ff, hsum_in;
   logic [15:0] tsum_ff, tsum_in;

   logic [15:0] pos, rel, word;
   logic [7:0]  b;
   logic        take, in_hdr, excl;

   // Absorb one byte into the running sums and captured fields
   always_comb begin
      b        = req_data.data_byte;
      pos      = cnt_ff;
      take     = cnt_ff != COUNT_MAX;
      cnt_in   = take ? cnt_ff + 16'd1 : cnt_ff;
      hlen_in  = (pos == 16'd0) ? {b[3:0], 2'b00} : hlen_ff;
      proto_in = (pos == 16'd9) ? b : proto_ff;
      dir_in   = (pos == 16'd0) ? req_data.mode : dir_ff;
      addrs_in = addrs_ff;
      ports_in = ports_ff;
      hsum_in  = hsum_ff;
      tsum_in  = tsum_ff;
      in_hdr   = pos < {10'b0, hlen_in};
      rel      = pos - {10'b0, hlen_in};
      word     = pos[0] ? {8'b0, b} : {b, 8'b0};
      excl     = ((proto_in == PROTO_TCP) && (rel == 16'd16 || rel == 16'd17)) ||
                 ((proto_in == PROTO_UDP) && (rel == 16'd6 || rel == 16'd7));
      for (int k = 0; k < 8; k++) begin
         if (pos == 16'(19 - k)) begin
            addrs_in[k*8 +: 8] = b;
         end
      end
      if (in_hdr) begin
         if (!(pos >= 16'd10 && pos < 16'd20)) begin
            hsum_in = oc_fold17({1'b0, hsum_ff} + {1'b0, word});
         end
      end else if (rel < 16'd4) begin
         for (int k = 0; k < 4; k++) begin
            if (rel == 16'(3 - k)) begin
               ports_in[k*8 +: 8] = b;
            end
         end
      end else if (!excl) begin
         tsum_in = oc_fold17({1'b0, tsum_ff} + {1'b0, word});
      end
      if (!take) begin
         cnt_in   = cnt_ff;
         hlen_in  = hlen_ff;
         proto_in = proto_ff;
         dir_in   = dir_ff;
         addrs_in = addrs_ff;
         ports_in = ports_ff;
         hsum_in  = hsum_ff;
         tsum_in  = tsum_ff;
      end
   end

   // Hold absorber state; clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset || last_acc) begin
         cnt_ff   <= '0;
         hlen_ff  <= '0;
         proto_ff <= '0;
         dir_ff   <= 1'b0;
         addrs_ff <= '0;
         ports_ff <= '0;
         hsum_ff  <= '0;
         tsum_ff  <= '0;
      end else if (accept) begin
         cnt_ff   <= cnt_in;
         hlen_ff  <= hlen_in;
         proto_ff <= proto_in;
         dir_ff   <= dir_in;
         addrs_ff <= addrs_in;
         ports_ff <= ports_in;
         hsum_ff  <= hsum_in;
         tsum_ff  <= tsum_in;
      end
   end

   // Packet summary register
   always_ff @(posedge clock) begin
      if (last_acc) begin
         s1_ff.n     <= cnt_in;
         s1_ff.ihl   <= hlen_in;
         s1_ff.proto <= proto_in;
         s1_ff.dir   <= dir_in;
         s1_ff.src_a <= addrs_in[63:32];
         s1_ff.dst_a <= addrs_in[31:0];
         s1_ff.src_p <= ports_in[31:16];
         s1_ff.dst_p <= ports_in[15:0];
         s1_ff.hsum  <= hsum_in;
         s1_ff.tsum  <= tsum_in;
      end
   end

   // Decide the rewrite and form the sums that do not need the table
   logic [16:0] n_x, ihl8, ihl20;
   logic        is_tcp, is_udp, base_ok, long8, long20;
   logic [15:0] pp, dst_p_e, len;
   logic [31:0] dst_a_e;
   logic [19:0] ip_acc, t_acc;

   always_comb begin
      n_x     = {1'b0, s1_ff.n};
      ihl8    = {11'b0, s1_ff.ihl} + 17'd8;
      ihl20   = {11'b0, s1_ff.ihl} + 17'd20;
      long8   = n_x >= ihl8;
      long20  = n_x >= ihl20;
      is_tcp  = s1_ff.proto == PROTO_TCP;
      is_udp  = s1_ff.proto == PROTO_UDP;
      base_ok = (s1_ff.n >= MIN_PACKET) && (s1_ff.ihl >= MIN_HEADER);
      pp      = is_tcp ? tcp_port_ff : udp_port_ff;
      s2_in.n         = s1_ff.n;
      s2_in.ihl       = s1_ff.ihl;
      s2_in.proto     = s1_ff.proto;
      s2_in.is_tcp    = is_tcp;
      s2_in.is_udp    = is_udp;
      s2_in.dir       = s1_ff.dir;
      s2_in.out_rw    = base_ok && !s1_ff.dir &&
                        ((is_tcp && long20 && s1_ff.dst_p != tcp_port_ff) ||
                         (is_udp && long8 && s1_ff.dst_p != udp_port_ff));
      s2_in.other_tel = base_ok && !s1_ff.dir && !is_tcp && !is_udp && long8;
      s2_in.in_cand   = base_ok && s1_ff.dir && (is_tcp || is_udp) && long8 &&
                        s1_ff.src_p == pp;
      s2_in.src_a     = s1_ff.src_a;
      s2_in.dst_a     = s1_ff.dst_a;
      s2_in.src_p     = s1_ff.src_p;
      s2_in.dst_p     = s1_ff.dst_p;
      s2_in.proxy_a   = proxy_a_ff;
      s2_in.proxy_p   = pp;
      dst_a_e = s2_in.out_rw ? proxy_a_ff : s1_ff.dst_a;
      dst_p_e = s2_in.out_rw ? pp : s1_ff.dst_p;
      len     = s1_ff.n - {10'b0, s1_ff.ihl};
      ip_acc  = {4'b0, s1_ff.hsum} + {4'b0, dst_a_e[31:16]} + {4'b0, dst_a_e[15:0]};
      t_acc   = {4'b0, s1_ff.tsum} + {4'b0, dst_p_e} + {4'b0, dst_a_e[31:16]} +
                {4'b0, dst_a_e[15:0]} + {12'b0, s1_ff.proto} + {4'b0, len};
      s2_in.ip_part = oc_fold20(ip_acc);
      s2_in.t_part  = oc_fold20(t_acc);
   end

   // Table access: outbound writes at the source port, inbound reads at the destination port
   tbl_req_type          tcp_req, udp_req;
   logic [PORT_BITS-1:0] tbl_index;
   nat_entry_type        wr_entry, tcp_rd, udp_rd;

   assign tbl_index      = s1_ff.dir ? s1_ff.dst_p[PORT_BITS-1:0] : s1_ff.src_p[PORT_BITS-1:0];
   assign wr_entry.valid = 1'b1;
   assign wr_entry.addr  = s1_ff.dst_a;
   assign wr_entry.port  = s1_ff.dst_p;
   assign tcp_req.wr_en  = s1_move && s2_in.out_rw && is_tcp;
   assign udp_req.wr_en  = s1_move && s2_in.out_rw && !is_tcp;
   assign tcp_req.rd_en  = s1_move && s1_ff.dir;
   assign udp_req.rd_en  = s1_move && s1_ff.dir;

   ipnat_table #(.PORT_BITS(PORT_BITS)) u_tcp_table (
      .clock    (clock),
      .reset    (reset),
      .req      (tcp_req),
      .index    (tbl_index),
      .wr_entry (wr_entry),
      .rd_entry (tcp_rd),
      .busy     (tcp_busy)
   );

   ipnat_table #(.PORT_BITS(PORT_BITS)) u_udp_table (
      .clock    (clock),
      .reset    (reset),
      .req      (udp_req),
      .index    (tbl_index),
      .wr_entry (wr_entry),
      .rd_entry (udp_rd),
      .busy     (udp_busy)
   );

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_ff <= s2_in;
      end
   end

   // Finish the checksums with the restored source and build the result word
   nat_entry_type ent;
   logic          in_rw, rw;
   logic [31:0]   src_a_e;
   logic [15:0]   src_p_e, ip_s, t_s, tck;

   always_comb begin
      ent     = s2_ff.is_tcp ? tcp_rd : udp_rd;
      in_rw   = s2_ff.in_cand && ent.valid;
      rw      = s2_ff.out_rw || in_rw;
      src_a_e = in_rw ? ent.addr : s2_ff.src_a;
      src_p_e = in_rw ? ent.port : s2_ff.src_p;
      ip_s    = oc_fold20({4'b0, s2_ff.ip_part} + {4'b0, src_a_e[31:16]} +
                          {4'b0, src_a_e[15:0]});
      t_s     = oc_fold20({4'b0, s2_ff.t_part} + {4'b0, src_p_e} +
                          {4'b0, src_a_e[31:16]} + {4'b0, src_a_e[15:0]});
      tck     = ~t_s;
      if (s2_ff.is_udp && tck == 16'd0) begin
         tck = 16'hFFFF;
      end
      rsp_in                    = '0;
      rsp_in.header_length      = s2_ff.ihl;
      rsp_in.protocol_number    = s2_ff.proto;
      rsp_in.packet_length      = s2_ff.n;
      rsp_in.rewritten          = rw;
      rsp_in.telemetry_valid    = rw || s2_ff.other_tel;
      if (rw) begin
         rsp_in.ip_header_checksum = ~ip_s;
         rsp_in.transport_checksum = tck;
      end
      if (s2_ff.out_rw) begin
         rsp_in.new_address    = s2_ff.proxy_a;
         rsp_in.new_port       = s2_ff.proxy_p;
         rsp_in.client_port    = s2_ff.src_p;
         rsp_in.remote_address = s2_ff.dst_a;
         rsp_in.server_port    = s2_ff.dst_p;
      end else if (in_rw) begin
         rsp_in.new_address    = ent.addr;
         rsp_in.new_port       = ent.port;
         rsp_in.client_port    = s2_ff.dst_p;
         rsp_in.remote_address = ent.addr;
         rsp_in.server_port    = ent.port;
      end else if (s2_ff.other_tel) begin
         rsp_in.remote_address = s2_ff.dst_a;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_ff <= rsp_in;
      end
   end

   // Stage valid bits
   always_comb begin
      s1_valid_in  = last_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_move ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
